// ===== design/cbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Cascaded biquad with coefficient ramp - shared definitions
// Types, register map and constants used by the filter cells, the ramp unit
// and the top level.
// ----------------------------------------------------------------------------
package cbr_pkg;

    // default sizing of the top level
    localparam int DEF_CHANNELS        = 2;
    localparam int DEF_MAX_STAGE_COUNT = 4;
    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int DEF_COEFF_FRAC_BITS = 20;

    // register port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int COEF_W       = 24;
    localparam int NCOEF        = 5;
    localparam int STAGE_CNT_W  = 3;
    localparam int RAMP_SHIFT_W = 4;
    localparam int REM_W        = 13;

    localparam logic [RAMP_SHIFT_W-1:0] RAMP_SHIFT_MAX   = 4'd12;
    localparam logic [RAMP_SHIFT_W-1:0] RESET_RAMP_SHIFT = 4'd7;
    localparam logic [STAGE_CNT_W-1:0]  RESET_STAGE_CNT  = 3'd1;

    // coefficient slots within a row
    localparam int C_B0 = 0;
    localparam int C_B1 = 1;
    localparam int C_B2 = 2;
    localparam int C_A1 = 3;
    localparam int C_A2 = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2,
        REG_STAGE_COUNT,
        REG_RAMP_SHIFT,
        REG_FILTER_ON
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RAMP,
        MODE_JUMP
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic en;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic setup;
        logic commit;
        logic retarget;
    } t_ramp_ctl;

    // target registers must hold the unity reset value of b0
    function automatic int tgt_width(input int frac);
        return (frac + 2 > COEF_W) ? frac + 2 : COEF_W;
    endfunction

endpackage

// ===== design/cascaded_biquad_ramped_unit.sv =====
// Filter on: an input transfer passes the setup state, the chain of biquad
// cells (each registers products, partial sums and output in turn), then
// the result and output registers. Filter off: the mix input passes only
// those two registers. One item at a time; the next waits for output load.
// Synchronous active-low reset: registers to reset values, coefficients jump
// to the targets on each channel's first filtered item.
// ----------------------------------------------------------------------------
// Cascaded biquad with coefficient ramp - top level
// Register file, sequencer, ramp unit and a chain of biquad cells; adds the
// filtered sample to the mix with saturation.
// ----------------------------------------------------------------------------
module cascaded_biquad_ramped_unit #(
    parameter  int CHANNELS        = cbr_pkg::DEF_CHANNELS,
    parameter  int MAX_STAGE_COUNT = cbr_pkg::DEF_MAX_STAGE_COUNT,
    parameter  int SAMPLE_BITS     = cbr_pkg::DEF_SAMPLE_BITS,
    parameter  int COEFF_FRAC_BITS = cbr_pkg::DEF_COEFF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_channel,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic signed [SAMPLE_BITS-1:0]      i_mix_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_mixed_out
);

    localparam int SB  = SAMPLE_BITS;
    localparam int TW  = cbr_pkg::tgt_width(COEFF_FRAC_BITS);
    localparam int CCW = TW + 1;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW  = $clog2(MAX_STAGE_COUNT + 1);
    localparam int SIW = (MAX_STAGE_COUNT > 1) ? $clog2(MAX_STAGE_COUNT) : 1;
    localparam logic signed [SB-1:0] Y_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] Y_MIN = {1'b1, {(SB-1){1'b0}}};

    // registers
    logic [cbr_pkg::NCOEF-1:0][TW-1:0]     r_tgt;
    logic [cbr_pkg::STAGE_CNT_W-1:0]       r_stage_cnt;
    logic [cbr_pkg::RAMP_SHIFT_W-1:0]      r_ramp_shift;
    logic                                  r_filter_on;

    cbr_pkg::t_state                       r_state, n_state;
    logic [NW-1:0]                         r_active, r_n, n_stage;
    logic                                  r_go;
    logic [CHW-1:0]                        r_ch, ch_idx;
    logic signed [SB-1:0]                  r_x, r_mix, r_res, r_out, mix_sat;
    logic signed [SB:0]                    mix_sum;
    logic                                  r_out_valid;
    logic                                  in_xfer, out_load;
    logic [3:0]                            sc_clamp;
    logic [SIW-1:0]                        tap_idx;

    cbr_pkg::t_ramp_ctl                    ramp_ctl;
    logic [cbr_pkg::NCOEF-1:0][CCW-1:0]    coef;
    cbr_pkg::t_cell_ctl                    cell_ctl [MAX_STAGE_COUNT];
    logic                                  v_in  [MAX_STAGE_COUNT];
    logic [CHW-1:0]                        ch_in [MAX_STAGE_COUNT];
    logic signed [SB-1:0]                  x_in  [MAX_STAGE_COUNT];
    logic                                  v_out [MAX_STAGE_COUNT];
    logic [CHW-1:0]                        ch_out[MAX_STAGE_COUNT];
    logic signed [SB-1:0]                  y_out [MAX_STAGE_COUNT];

    assign ch_idx     = (CHANNELS > 1) ? CHW'(i_channel) : '0;
    assign o_in_ready = (r_state == cbr_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid & o_in_ready;
    assign out_load   = (r_state == cbr_pkg::ST_OUT) & (~r_out_valid | i_out_ready);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cbr_pkg::NCOEF; k++) begin
                r_tgt[k] <= (k == cbr_pkg::C_B0) ? TW'(1) << COEFF_FRAC_BITS : TW'(0);
            end
            r_stage_cnt  <= cbr_pkg::RESET_STAGE_CNT;
            r_ramp_shift <= cbr_pkg::RESET_RAMP_SHIFT;
            r_filter_on  <= 1'b1;
        end else if (i_cfg_we) begin
            case (cbr_pkg::t_reg_idx'(i_cfg_idx))
                cbr_pkg::REG_B0, cbr_pkg::REG_B1, cbr_pkg::REG_B2,
                cbr_pkg::REG_A1, cbr_pkg::REG_A2: begin
                    r_tgt[i_cfg_idx] <= TW'($signed(i_cfg_data));
                end
                cbr_pkg::REG_STAGE_COUNT: begin
                    r_stage_cnt <= i_cfg_data[cbr_pkg::STAGE_CNT_W-1:0];
                end
                cbr_pkg::REG_RAMP_SHIFT: begin
                    r_ramp_shift <= i_cfg_data[cbr_pkg::RAMP_SHIFT_W-1:0];
                end
                cbr_pkg::REG_FILTER_ON: begin
                    r_filter_on <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage count clamped to 1..MAX_STAGE_COUNT
    always_comb begin
        if (r_stage_cnt == '0) begin
            sc_clamp = 4'd1;
        end else if ({1'b0, r_stage_cnt} > 4'(MAX_STAGE_COUNT)) begin
            sc_clamp = 4'(MAX_STAGE_COUNT);
        end else begin
            sc_clamp = {1'b0, r_stage_cnt};
        end
        n_stage = NW'(sc_clamp);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cbr_pkg::ST_IDLE;
            r_active <= '0;
            r_n      <= '0;
            r_go     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (r_state == cbr_pkg::ST_SETUP);
            if (r_state == cbr_pkg::ST_SETUP) begin
                r_active <= n_stage;
                r_n      <= n_stage;
            end
        end
    end

    always_comb begin
        n_state           = r_state;
        ramp_ctl.setup    = 1'b0;
        ramp_ctl.commit   = 1'b0;
        ramp_ctl.retarget = i_cfg_we & (i_cfg_idx <= cbr_pkg::REG_A2);
        case (r_state)
            cbr_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = r_filter_on ? cbr_pkg::ST_SETUP : cbr_pkg::ST_OUT;
                end
            end
            cbr_pkg::ST_SETUP: begin
                ramp_ctl.setup = 1'b1;
                n_state        = cbr_pkg::ST_RUN;
            end
            cbr_pkg::ST_RUN: begin
                ramp_ctl.commit = r_go;
                if (v_out[tap_idx]) begin
                    n_state = cbr_pkg::ST_OUT;
                end
            end
            cbr_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = cbr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cbr_pkg::ST_IDLE;
            end
        endcase
    end

    // last stage output into the mix
    assign tap_idx = SIW'(r_n - NW'(1));
    always_comb begin
        mix_sum = (SB+1)'(r_mix) + (SB+1)'(y_out[tap_idx]);
        if (mix_sum[SB] == mix_sum[SB-1]) begin
            mix_sat = mix_sum[SB-1:0];
        end else if (mix_sum[SB]) begin
            mix_sat = Y_MIN;
        end else begin
            mix_sat = Y_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch  <= ch_idx;
            r_x   <= i_sample;
            r_mix <= i_mix_in;
            r_res <= i_mix_in;
        end else if (r_state == cbr_pkg::ST_RUN && v_out[tap_idx]) begin
            r_res <= mix_sat;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mixed_out = r_out;

    cbr_ramp #(
        .CHANNELS        (CHANNELS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ramp_ctl),
        .i_ch    (r_ch),
        .i_tgt   (r_tgt),
        .i_shift (r_ramp_shift),
        .o_coef  (coef)
    );

    // cell chain: stages past the active count stay idle; newly enabled
    // stages are cleared in the setup cycle
    always_comb begin
        v_in[0]  = r_go;
        ch_in[0] = r_ch;
        x_in[0]  = r_x;
        for (int s = 0; s < MAX_STAGE_COUNT; s++) begin
            cell_ctl[s].en    = (s < r_n);
            cell_ctl[s].clear = (r_state == cbr_pkg::ST_SETUP) && (s >= r_active)
                                && (s < n_stage);
        end
        for (int s = 1; s < MAX_STAGE_COUNT; s++) begin
            v_in[s]  = v_out[s-1];
            ch_in[s] = ch_out[s-1];
            x_in[s]  = y_out[s-1];
        end
    end

    for (genvar s = 0; s < MAX_STAGE_COUNT; s++) begin : g_stage
        cbr_cell #(
            .CHANNELS        (CHANNELS),
            .SAMPLE_BITS     (SAMPLE_BITS),
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[s]),
            .i_coef  (coef),
            .i_valid (v_in[s]),
            .i_ch    (ch_in[s]),
            .i_x     (x_in[s]),
            .o_valid (v_out[s]),
            .o_ch    (ch_out[s]),
            .o_y     (y_out[s])
        );
    end

endmodule

// ===== design/cbr_cell.sv =====
// ----------------------------------------------------------------------------
// Biquad cell
// One direct-form-I stage: five products, two partial sums, round and
// saturate. Holds x[n-1], x[n-2], y[n-1], y[n-2] for every channel and
// hands its output to the next cell of the chain.
// ----------------------------------------------------------------------------
module cbr_cell #(
    parameter  int CHANNELS        = cbr_pkg::DEF_CHANNELS,
    parameter  int SAMPLE_BITS     = cbr_pkg::DEF_SAMPLE_BITS,
    parameter  int COEFF_FRAC_BITS = cbr_pkg::DEF_COEFF_FRAC_BITS,
    localparam int TW  = cbr_pkg::tgt_width(COEFF_FRAC_BITS),
    localparam int CCW = TW + 1,
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cbr_pkg::t_cell_ctl                      i_ctl,
    input  logic [cbr_pkg::NCOEF-1:0][CCW-1:0]      i_coef,
    input  logic                                    i_valid,
    input  logic [CHW-1:0]                          i_ch,
    input  logic signed [SAMPLE_BITS-1:0]           i_x,
    output logic                                    o_valid,
    output logic [CHW-1:0]                          o_ch,
    output logic signed [SAMPLE_BITS-1:0]           o_y
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = CCW + SB;
    localparam int AW = PW + 3;
    localparam logic signed [AW-1:0] RND = {{(AW-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
    localparam logic signed [SB-1:0] Y_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] Y_MIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [SB-1:0] r_hx1 [CHANNELS];
    logic signed [SB-1:0] r_hx2 [CHANNELS];
    logic signed [SB-1:0] r_hy1 [CHANNELS];
    logic signed [SB-1:0] r_hy2 [CHANNELS];

    logic signed [SB-1:0] ops [cbr_pkg::NCOEF];
    logic signed [PW-1:0] n_p [cbr_pkg::NCOEF];
    logic signed [PW-1:0] r_p [cbr_pkg::NCOEF];
    logic signed [SB-1:0] r_x;
    logic [CHW-1:0]       r_ch;
    logic                 r_v1, r_v2, r_v3;
    logic signed [AW-1:0] r_sa, r_sb;
    logic signed [AW-1:0] acc, shd;
    logic                 in_rng;
    logic signed [SB-1:0] y_sat;
    logic signed [SB-1:0] r_y;
    logic                 start;

    assign start = i_valid & i_ctl.en;

    // product terms
    always_comb begin
        ops[cbr_pkg::C_B0] = i_x;
        ops[cbr_pkg::C_B1] = r_hx1[i_ch];
        ops[cbr_pkg::C_B2] = r_hx2[i_ch];
        ops[cbr_pkg::C_A1] = r_hy1[i_ch];
        ops[cbr_pkg::C_A2] = r_hy2[i_ch];
        for (int k = 0; k < cbr_pkg::NCOEF; k++) begin
            n_p[k] = $signed(i_coef[k]) * ops[k];
        end
    end

    // round half up, then clamp to sample range
    always_comb begin
        acc    = r_sa + r_sb + RND;
        shd    = acc >>> COEFF_FRAC_BITS;
        in_rng = (&shd[AW-1:SB-1]) | ~(|shd[AW-1:SB-1]);
        if (in_rng) begin
            y_sat = shd[SB-1:0];
        end else if (shd[AW-1]) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = Y_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_p  <= n_p;
            r_x  <= i_x;
            r_ch <= i_ch;
        end
        if (r_v1) begin
            r_sa <= AW'(r_p[cbr_pkg::C_B0]) + AW'(r_p[cbr_pkg::C_B1])
                  + AW'(r_p[cbr_pkg::C_B2]);
            r_sb <= AW'(r_p[cbr_pkg::C_A1]) + AW'(r_p[cbr_pkg::C_A2]);
        end
        if (r_v2) begin
            r_y <= y_sat;
        end
    end

    // history: cleared as a whole when the stage comes into use
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_hx1[c] <= '0;
                r_hx2[c] <= '0;
                r_hy1[c] <= '0;
                r_hy2[c] <= '0;
            end
        end else if (r_v2) begin
            r_hx2[r_ch] <= r_hx1[r_ch];
            r_hx1[r_ch] <= r_x;
            r_hy2[r_ch] <= r_hy1[r_ch];
            r_hy1[r_ch] <= y_sat;
        end
    end

    assign o_valid = r_v3;
    assign o_ch    = r_ch;
    assign o_y     = r_y;

endmodule

// ===== design/cbr_ramp.sv =====
// ----------------------------------------------------------------------------
// Coefficient ramp unit
// Per channel coefficient set, ramp steps, remaining count and retarget
// mode. Setup builds the working set for one item, commit writes back the
// set, advanced by one ramp step while a ramp is under way.
// ----------------------------------------------------------------------------
module cbr_ramp #(
    parameter  int CHANNELS        = cbr_pkg::DEF_CHANNELS,
    parameter  int COEFF_FRAC_BITS = cbr_pkg::DEF_COEFF_FRAC_BITS,
    localparam int TW  = cbr_pkg::tgt_width(COEFF_FRAC_BITS),
    localparam int CCW = TW + 1,
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cbr_pkg::t_ramp_ctl                      i_ctl,
    input  logic [CHW-1:0]                          i_ch,
    input  logic [cbr_pkg::NCOEF-1:0][TW-1:0]       i_tgt,
    input  logic [cbr_pkg::RAMP_SHIFT_W-1:0]        i_shift,
    output logic [cbr_pkg::NCOEF-1:0][CCW-1:0]      o_coef
);

    localparam int RW = cbr_pkg::REM_W;

    logic [cbr_pkg::NCOEF-1:0][CCW-1:0] r_cur  [CHANNELS];
    logic [cbr_pkg::NCOEF-1:0][CCW-1:0] r_step [CHANNELS];
    logic [RW-1:0]                      r_rem  [CHANNELS];
    cbr_pkg::t_mode                     r_mode [CHANNELS];

    logic [cbr_pkg::NCOEF-1:0][CCW-1:0] r_wc, r_ws, n_wc, n_ws, upd, tgt_ext;
    logic [RW-1:0]                      r_wr, n_wr;
    logic [cbr_pkg::RAMP_SHIFT_W-1:0]   sh;
    logic signed [CCW:0]                diff [cbr_pkg::NCOEF];
    logic signed [CCW:0]                stepv [cbr_pkg::NCOEF];

    assign sh = (i_shift > cbr_pkg::RAMP_SHIFT_MAX) ? cbr_pkg::RAMP_SHIFT_MAX : i_shift;

    always_comb begin
        for (int k = 0; k < cbr_pkg::NCOEF; k++) begin
            tgt_ext[k] = CCW'($signed(i_tgt[k]));
            diff[k]    = (CCW+1)'($signed(tgt_ext[k])) - (CCW+1)'($signed(r_cur[i_ch][k]));
            stepv[k]   = diff[k] >>> sh;
        end
        case (r_mode[i_ch])
            cbr_pkg::MODE_JUMP: begin
                n_wc = tgt_ext;
                n_ws = '0;
                n_wr = '0;
            end
            cbr_pkg::MODE_RAMP: begin
                n_wc = r_cur[i_ch];
                for (int k = 0; k < cbr_pkg::NCOEF; k++) begin
                    n_ws[k] = (sh == '0) ? '0 : CCW'(stepv[k]);
                end
                n_wr = RW'(1) << sh;
            end
            default: begin
                n_wc = r_cur[i_ch];
                n_ws = r_step[i_ch];
                n_wr = r_rem[i_ch];
            end
        endcase
    end

    // one ramp step; the last one lands exactly on the targets
    always_comb begin
        for (int k = 0; k < cbr_pkg::NCOEF; k++) begin
            if (r_wr == '0) begin
                upd[k] = r_wc[k];
            end else if (r_wr == RW'(1)) begin
                upd[k] = tgt_ext[k];
            end else begin
                upd[k] = r_wc[k] + r_ws[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_mode[c] <= cbr_pkg::MODE_JUMP;
                r_rem[c]  <= '0;
            end
        end else begin
            if (i_ctl.retarget) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (r_mode[c] != cbr_pkg::MODE_JUMP) begin
                        r_mode[c] <= cbr_pkg::MODE_RAMP;
                    end
                end
            end
            if (i_ctl.setup) begin
                r_mode[i_ch] <= cbr_pkg::MODE_IDLE;
            end
            if (i_ctl.commit) begin
                r_rem[i_ch] <= (r_wr == '0) ? '0 : r_wr - RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.setup) begin
            r_wc <= n_wc;
            r_ws <= n_ws;
            r_wr <= n_wr;
        end
        if (i_ctl.commit) begin
            r_cur[i_ch]  <= upd;
            r_step[i_ch] <= r_ws;
        end
    end

    assign o_coef = r_wc;

endmodule

// ===== design/cbr_checker.sv =====
// ----------------------------------------------------------------------------
// Cascaded biquad with coefficient ramp - port checker
// Watches the top level's handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module cbr_checker #(
    parameter int SAMPLE_BITS = cbr_pkg::DEF_SAMPLE_BITS
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_BITS-1:0]  o_mixed_out
);

    // result held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_mixed_out))
        else $error("stalled result changed");

    // one item at a time: never two input transfers back to back
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // a fresh result leaves the block free for the next item
    a_free_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result raised while still busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset state wrong");

endmodule

bind cascaded_biquad_ramped_unit cbr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_mixed_out (o_mixed_out)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the cascaded biquad unit with coefficient ramp
// Drives audio items over the valid/ready input and checks every mixed
// result against a bit-exact predictor of the filter, the ramp and the mix.
// A directed part covers extremes and corner cases, then random phases
// reprogram the registers between bursts. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_N          = 2;
    localparam int STAGES_N      = 4;
    localparam int SMP_W         = 24;
    localparam int FRAC          = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_LEN      = 250;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 480;
    localparam int CFG_W         = cbr_pkg::CFG_DATA_W;
    localparam int SC_W          = cbr_pkg::STAGE_CNT_W;
    localparam int RS_W          = cbr_pkg::RAMP_SHIFT_W;

    localparam longint SMP_MAX = (longint'(1) <<< (SMP_W - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    // history slots per stage
    localparam int H_X1 = 0;
    localparam int H_X2 = 1;
    localparam int H_Y1 = 2;
    localparam int H_Y2 = 3;

    typedef struct {
        int unsigned             seq;
        logic signed [SMP_W-1:0] mixed;
    } t_mix_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [cbr_pkg::CFG_IDX_W-1:0]     i_cfg_idx   = '0;
    logic [CFG_W-1:0]                  i_cfg_data  = '0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic                              i_channel   = 1'b0;
    logic signed [SMP_W-1:0]           i_sample    = '0;
    logic signed [SMP_W-1:0]           i_mix_in    = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [SMP_W-1:0]           o_mixed_out;

    cascaded_biquad_ramped_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_channel   (i_channel),
        .i_sample    (i_sample),
        .i_mix_in    (i_mix_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_mixed_out (o_mixed_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    longint          tgt_coef [cbr_pkg::NCOEF];
    int unsigned     stage_sel;
    int unsigned     shift_sel;
    bit              filter_en;
    longint          hist [CH_N][STAGES_N][4];
    longint          cur_coef [CH_N][cbr_pkg::NCOEF];
    longint          coef_step [CH_N][cbr_pkg::NCOEF];
    int unsigned     ramp_left [CH_N];
    cbr_pkg::t_mode  chan_mode [CH_N];
    int unsigned     live_stages;

    t_mix_result expected_mix_q [$];
    int unsigned sent_count  = 0;
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_gaps     = 1'b1;
    bit          rx_gaps     = 1'b1;
    bit          hold_req    = 1'b0;
    bit          hold_seen   = 1'b0;
    int unsigned hold_left   = 0;

    function automatic logic signed [SMP_W-1:0] sat_q23(input longint v);
        if (v > SMP_MAX) return SMP_MAX[SMP_W-1:0];
        if (v < SMP_MIN) return SMP_MIN[SMP_W-1:0];
        return v[SMP_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] biquad_mix_predict(input int ch,
            input longint x_in, input longint mix_in);
        longint      x;
        longint      acc;
        longint      y;
        int unsigned n;
        int unsigned sh;
        if (!filter_en) return mix_in[SMP_W-1:0];
        n = (stage_sel < 1) ? 1 : ((stage_sel > STAGES_N) ? STAGES_N : stage_sel);
        // stages coming into use start clean on every channel
        if (n > live_stages) begin
            for (int c = 0; c < CH_N; c++)
                for (int s = live_stages; s < n; s++)
                    for (int k = 0; k < 4; k++) hist[c][s][k] = 0;
        end
        live_stages = n;
        case (chan_mode[ch])
            cbr_pkg::MODE_JUMP: begin
                for (int i = 0; i < cbr_pkg::NCOEF; i++) begin
                    cur_coef[ch][i]  = tgt_coef[i];
                    coef_step[ch][i] = 0;
                end
                ramp_left[ch] = 0;
            end
            cbr_pkg::MODE_RAMP: begin
                sh = (shift_sel > cbr_pkg::RAMP_SHIFT_MAX) ? cbr_pkg::RAMP_SHIFT_MAX
                                                           : shift_sel;
                for (int i = 0; i < cbr_pkg::NCOEF; i++)
                    coef_step[ch][i] = (sh == 0) ? 0 : (tgt_coef[i] - cur_coef[ch][i]) >>> sh;
                ramp_left[ch] = 1 << sh;
            end
            default: ;
        endcase
        chan_mode[ch] = cbr_pkg::MODE_IDLE;
        x = x_in;
        for (int s = 0; s < n; s++) begin
            acc = cur_coef[ch][cbr_pkg::C_B0] * x
                + cur_coef[ch][cbr_pkg::C_B1] * hist[ch][s][H_X1]
                + cur_coef[ch][cbr_pkg::C_B2] * hist[ch][s][H_X2]
                + cur_coef[ch][cbr_pkg::C_A1] * hist[ch][s][H_Y1]
                + cur_coef[ch][cbr_pkg::C_A2] * hist[ch][s][H_Y2];
            y = sat_q23((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
            hist[ch][s][H_X2] = hist[ch][s][H_X1];
            hist[ch][s][H_X1] = x;
            hist[ch][s][H_Y2] = hist[ch][s][H_Y1];
            hist[ch][s][H_Y1] = y;
            x = y;
        end
        // coefficients advance after use; the last ramp sample lands exactly
        if (ramp_left[ch] > 0) begin
            for (int i = 0; i < cbr_pkg::NCOEF; i++)
                cur_coef[ch][i] = (ramp_left[ch] == 1) ? tgt_coef[i]
                                                       : cur_coef[ch][i] + coef_step[ch][i];
            ramp_left[ch]--;
        end
        return sat_q23(mix_in + x);
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < 10) $display("mismatch: %s", msg);
        fault_count++;
    endfunction

    function automatic logic [CFG_W-1:0] rand_span(input int unsigned span);
        int v;
        v = int'($urandom_range(2 * span)) - int'(span);
        return v[CFG_W-1:0];
    endfunction

    // receiver: result check, random idling and the long hold-off
    always @(posedge i_clk) begin
        t_mix_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_mix_q.size() == 0) begin
                note_fault($sformatf("result %0d with nothing expected", o_mixed_out));
            end else begin
                exp_r = expected_mix_q.pop_front();
                if (o_mixed_out !== exp_r.mixed)
                    note_fault($sformatf("item %0d mixed_out expected %0d got %0d",
                                         exp_r.seq, exp_r.mixed, o_mixed_out));
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(rx_gaps && $urandom_range(99) < 26);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input cbr_pkg::t_reg_idx idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cbr_pkg::REG_B0, cbr_pkg::REG_B1, cbr_pkg::REG_B2,
            cbr_pkg::REG_A1, cbr_pkg::REG_A2: begin
                tgt_coef[int'(idx)] = longint'(signed'(d));
                // a pending jump wins over a new ramp
                for (int c = 0; c < CH_N; c++)
                    if (chan_mode[c] != cbr_pkg::MODE_JUMP) chan_mode[c] = cbr_pkg::MODE_RAMP;
            end
            cbr_pkg::REG_STAGE_COUNT: stage_sel = 32'(d[SC_W-1:0]);
            cbr_pkg::REG_RAMP_SHIFT:  shift_sel = 32'(d[RS_W-1:0]);
            cbr_pkg::REG_FILTER_ON:   filter_en = d[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(input bit ch, input logic signed [SMP_W-1:0] smp,
                               input logic signed [SMP_W-1:0] mix);
        t_mix_result r;
        while (tx_gaps && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= ch;
        i_sample   <= smp;
        i_mix_in   <= mix;
        // ready is taken as it stands at the edge itself
        @(posedge i_clk iff o_in_ready);
        r.seq   = sent_count++;
        r.mixed = biquad_mix_predict(int'(ch), smp, mix);
        expected_mix_q = {expected_mix_q, r};
    endtask

    // block idle before register writes: every transfer answered
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_jump_on_first_item();
        write_reg(cbr_pkg::REG_B0, 24'd524288);
        write_reg(cbr_pkg::REG_A1, rand_span(800000));
        send_sample(1'b0, 24'sh7fffff, 24'sd0);
        settle_idle();
        // channel 0 now ramps, channel 1 still jumps straight to the targets
        write_reg(cbr_pkg::REG_B1, 24'd262144);
        send_sample(1'b1, 24'sh123456, 24'sd0);
        send_sample(1'b0, 24'sh654321, 24'sd0);
    endtask

    task automatic test_sample_extremes();
        send_sample(1'b0, 24'sh7fffff, 24'sh7fffff);
        send_sample(1'b1, 24'sh800000, 24'sh800000);
        send_sample(1'b0, 24'sd0, 24'sd0);
        send_sample(1'b1, 24'sh7fffff, 24'sh800000);
        send_sample(1'b0, 24'sh800000, 24'sh7fffff);
    endtask

    task automatic test_ramp_shift_limits();
        settle_idle();
        write_reg(cbr_pkg::REG_RAMP_SHIFT, 24'd0);
        write_reg(cbr_pkg::REG_B2, rand_span(1048576));
        send_sample(1'b0, 24'sh400000, 24'sd100);
        send_sample(1'b0, 24'shc00000, 24'sd0);
        settle_idle();
        // above the top shift, saturates to the longest ramp
        write_reg(cbr_pkg::REG_RAMP_SHIFT, 24'd15);
        write_reg(cbr_pkg::REG_A2, rand_span(700000));
        send_sample(1'b1, 24'sh200000, 24'sd0);
        send_sample(1'b0, 24'sh300000, 24'sd0);
        settle_idle();
        // new target mid-ramp restarts from the current values
        write_reg(cbr_pkg::REG_RAMP_SHIFT, 24'd2);
        write_reg(cbr_pkg::REG_B0, 24'hf00000);
        send_sample(1'b0, 24'sh100000, 24'sd0);
        send_sample(1'b1, 24'sh100000, 24'sd0);
    endtask

    task automatic test_stage_limits();
        settle_idle();
        write_reg(cbr_pkg::REG_STAGE_COUNT, 24'd0);
        send_sample(1'b0, 24'sh3fffff, 24'sd0);
        settle_idle();
        write_reg(cbr_pkg::REG_STAGE_COUNT, 24'd7);
        send_sample(1'b1, 24'shc00001, 24'sd0);
        send_sample(1'b0, 24'sh0fffff, 24'sd0);
        settle_idle();
        write_reg(cbr_pkg::REG_STAGE_COUNT, 24'd2);
        send_sample(1'b0, 24'sh200000, 24'sd0);
        settle_idle();
        write_reg(cbr_pkg::REG_STAGE_COUNT, 24'd4);
        send_sample(1'b1, 24'sh200000, 24'sd0);
    endtask

    task automatic test_filter_bypass();
        settle_idle();
        write_reg(cbr_pkg::REG_FILTER_ON, 24'd0);
        send_sample(1'b0, 24'sh7fffff, 24'sh555555);
        send_sample(1'b1, 24'sh800000, 24'shaaaaaa);
        settle_idle();
        write_reg(cbr_pkg::REG_A1, rand_span(1200000));
        write_reg(cbr_pkg::REG_FILTER_ON, 24'hfffff1);
        send_sample(1'b0, 24'sh111111, 24'sd0);
        send_sample(1'b1, 24'sh222222, 24'sd0);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        settle_idle();
        tx_gaps = 1'b0;
        hold_req <= ~hold_req;
        repeat (24) send_sample(1'($urandom_range(1)), SMP_W'($urandom()), SMP_W'($urandom()));
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_phases(input int unsigned total);
        int unsigned             done;
        int unsigned             phase_len;
        int unsigned             phase_no;
        logic [CFG_W-1:0]        d;
        logic signed [SMP_W-1:0] smp;
        cbr_pkg::t_reg_idx       idx;
        done     = 0;
        phase_no = 0;
        while (done < total) begin
            settle_idle();
            // one early phase runs with no idling on either side
            tx_gaps = (phase_no != 1);
            rx_gaps <= (phase_no != 1);
            for (int r = int'(cbr_pkg::REG_B0); r <= int'(cbr_pkg::REG_FILTER_ON); r++) begin
                if ($urandom_range(1) == 0) continue;
                idx = cbr_pkg::t_reg_idx'(r);
                d   = CFG_W'($urandom());
                case (idx)
                    cbr_pkg::REG_B0, cbr_pkg::REG_B1, cbr_pkg::REG_B2:
                        if ($urandom_range(3) != 0) d = rand_span(1048576);
                    cbr_pkg::REG_A1: if ($urandom_range(3) != 0) d = rand_span(1677722);
                    cbr_pkg::REG_A2: if ($urandom_range(3) != 0) d = rand_span(838861);
                    cbr_pkg::REG_STAGE_COUNT: d[SC_W-1:0] = SC_W'($urandom_range(7));
                    cbr_pkg::REG_RAMP_SHIFT:
                        d[RS_W-1:0] = ($urandom_range(4) == 0) ? RS_W'($urandom_range(15))
                                                               : RS_W'($urandom_range(5));
                    cbr_pkg::REG_FILTER_ON: d[0] = ($urandom_range(99) < 85);
                    default: ;
                endcase
                write_reg(idx, d);
            end
            phase_len = $urandom_range(10, 40);
            repeat (phase_len) begin
                case ($urandom_range(9))
                    0:       smp = 24'sh7fffff;
                    1:       smp = 24'sh800000;
                    2:       smp = SMP_W'($urandom_range(255) - 128);
                    default: smp = SMP_W'($urandom());
                endcase
                send_sample(1'($urandom_range(1)), smp, SMP_W'($urandom()));
            end
            done += phase_len;
            phase_no++;
        end
        tx_gaps = 1'b1;
        rx_gaps <= 1'b1;
    endtask

    initial begin
        for (int i = 0; i < cbr_pkg::NCOEF; i++) tgt_coef[i] = 0;
        tgt_coef[cbr_pkg::C_B0] = longint'(1) <<< FRAC;
        stage_sel   = 32'(cbr_pkg::RESET_STAGE_CNT);
        shift_sel   = 32'(cbr_pkg::RESET_RAMP_SHIFT);
        filter_en   = 1'b1;
        live_stages = 0;
        for (int c = 0; c < CH_N; c++) begin
            for (int s = 0; s < STAGES_N; s++)
                for (int k = 0; k < 4; k++) hist[c][s][k] = 0;
            for (int i = 0; i < cbr_pkg::NCOEF; i++) begin
                cur_coef[c][i]  = 0;
                coef_step[c][i] = 0;
            end
            ramp_left[c] = 0;
            chan_mode[c] = cbr_pkg::MODE_JUMP;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_jump_on_first_item();
        test_sample_extremes();
        test_ramp_shift_limits();
        test_stage_limits();
        test_filter_bypass();
        test_backpressure();
        test_random_phases(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/cbr_pkg.sv
design/cbr_cell.sv
design/cbr_ramp.sv
design/cascaded_biquad_ramped_unit.sv
design/cbr_checker.sv
tb/tb_top.sv
